// ===== rtl/core/wbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// wbtc_pkg
// Shared types and constants of the word boundary text chunker: default
// sizes, byte codes, flag layout, result record and sequencer states.
// ----------------------------------------------------------------------------
package wbtc_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned MAX_CHUNK_DEF    = 67;
  localparam int unsigned WINDOW_DEPTH_DEF = 68;
  localparam int unsigned OFFSET_BITS_DEF  = 16;

  // Fixed field widths
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned FLAG_W = 2;

  // Chunk limit after reset
  localparam logic [CFG_W-1:0] LIMIT_RST = 7'd67;

  // Byte classification
  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;

  // Bit positions inside one window flag entry
  localparam int unsigned FLAG_SPACE_BIT = 0;
  localparam int unsigned FLAG_CONT_BIT  = 1;

  // One result record
  typedef struct packed {
    logic [OUT_W-1:0] chunk_start;
    logic [OUT_W-1:0] chunk_end;
    logic [OUT_W-1:0] chunk_index;
    logic             chunk_valid;
    logic             end_of_text;
    logic             overflow;
  } rec_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_DECIDE,
    S_SP_RD,
    S_SP_CHK,
    S_CT_RD,
    S_CT_CHK,
    S_TR_RD,
    S_TR_CHK,
    S_EMIT,
    S_SK_RD,
    S_SK_CHK,
    S_ADV,
    S_FIN
  } state_e;

endpackage

// ===== rtl/core/wbtc_if.sv =====
// ----------------------------------------------------------------------------
// wbtc_if
// Valid/ready channels of the chunker: text bytes in, chunk records out.
// ----------------------------------------------------------------------------
interface wbtc_in_if import wbtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface wbtc_out_if import wbtc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] chunk_start;
  logic [OUT_W-1:0] chunk_end;
  logic [OUT_W-1:0] chunk_index;
  logic             chunk_valid;
  logic             end_of_text;
  logic             overflow;

  modport source (output valid, output chunk_start, output chunk_end,
                  output chunk_index, output chunk_valid, output end_of_text,
                  output overflow, input ready);
  modport sink   (input valid, input chunk_start, input chunk_end,
                  input chunk_index, input chunk_valid, input end_of_text,
                  input overflow, output ready);
endinterface

// ===== rtl/core/word_boundary_text_chunker.sv =====
// ----------------------------------------------------------------------------
// word_boundary_text_chunker
// Streams text bytes in and reports word-wrapped chunk boundaries out.
// ----------------------------------------------------------------------------
// Takes one byte per transfer and returns chunk records (start, end, index)
// of at most chunk_limit bytes, split at the last space or, failing that, at
// the limit backed off to a UTF-8 character start. A byte that completes no
// chunk holds the input while it is taken, counted and stored, and decided
// on; the next byte is not taken before that. A byte that completes a chunk
// walks the flag window through one RAM read port, each flag probed with a
// read and then a check: the backward space search (up to L probes, with
// L = chunk_limit), the continuation back-off on a hard break (up to L),
// trailing-space trimming and the forward skip of spaces after the split,
// besides taking the byte, deciding, emitting and advancing the window.
// When the limit was lowered part-way through a text, the forward skip can
// pass further spaces. After the final byte, a remaining chunk is trimmed
// of trailing spaces and emitted as the closing record. A finished record
// waits in an output register while the next byte is taken; a second record
// of the same byte waits in the sequencer until that register is free.
// There is no clearing pass after reset.
module word_boundary_text_chunker import wbtc_pkg::*; #(
  parameter int unsigned MAX_CHUNK    = MAX_CHUNK_DEF,
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  wbtc_in_if.sink          text_i,
  wbtc_out_if.source       chunk_o
);

  logic [CFG_W-1:0] chunk_limit_q;
  logic             push;
  logic             out_free;
  rec_t             rec_core;
  rec_t             rec_out;

  // Chunk limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      chunk_limit_q <= cfg_wdata_i;
    end
  end

  // Sequencer and window
  wbtc_core #(
    .MAX_CHUNK    (MAX_CHUNK),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chunk_limit_i (chunk_limit_q),
    .in_valid_i    (text_i.valid),
    .in_ready_o    (text_i.ready),
    .text_byte_i   (text_i.text_byte),
    .final_byte_i  (text_i.final_byte),
    .push_o        (push),
    .rec_o         (rec_core),
    .out_free_i    (out_free)
  );

  // Result register
  wbtc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec_i       (rec_core),
    .free_o      (out_free),
    .out_ready_i (chunk_o.ready),
    .out_valid_o (chunk_o.valid),
    .rec_o       (rec_out)
  );

  assign chunk_o.chunk_start = rec_out.chunk_start;
  assign chunk_o.chunk_end   = rec_out.chunk_end;
  assign chunk_o.chunk_index = rec_out.chunk_index;
  assign chunk_o.chunk_valid = rec_out.chunk_valid;
  assign chunk_o.end_of_text = rec_out.end_of_text;
  assign chunk_o.overflow    = rec_out.overflow;

endmodule

// ===== rtl/core/wbtc_ram.sv =====
// ----------------------------------------------------------------------------
// wbtc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wbtc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 68
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/wbtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// wbtc_out_stage
// One-entry output register for result records; frees the sequencer as
// soon as the held record is transferred.
// ----------------------------------------------------------------------------
module wbtc_out_stage import wbtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic free_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output rec_t rec_o
);

  logic valid_q, valid_d;
  rec_t rec_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Record payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

// ===== rtl/core/wbtc_core.sv =====
// ----------------------------------------------------------------------------
// wbtc_core
// Sequencer and datapath: keeps the flag window in a circular RAM and walks
// it one probe at a time through a shared address unit to find each split.
// ----------------------------------------------------------------------------
module wbtc_core import wbtc_pkg::*; #(
  parameter int unsigned MAX_CHUNK    = MAX_CHUNK_DEF,
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CFG_W-1:0]  chunk_limit_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] text_byte_i,
  input  logic              final_byte_i,
  output logic              push_o,
  output rec_t              rec_o,
  input  logic              out_free_i
);

  localparam int unsigned SPAN   = (WINDOW_DEPTH > MAX_CHUNK) ? WINDOW_DEPTH : MAX_CHUNK;
  localparam int unsigned IDX_W  = $clog2(SPAN + 1);
  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W  = IDX_W + 1;

  localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);
  localparam logic [IDX_W-1:0] LIM_MAX = IDX_W'(MAX_CHUNK);
  localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

  // Saturating offset add
  function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                     input logic [IDX_W-1:0]       b);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + (OFFSET_BITS+1)'(b);
    return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
  endfunction

  state_e state_q, state_d;

  logic                   sp_q, sp_d;
  logic                   ct_q, ct_d;
  logic                   fin_q, fin_d;
  logic [IDX_W-1:0]       lim_q, lim_d;
  logic [IDX_W-1:0]       fill_q, fill_d;
  logic [ADDR_W-1:0]      head_q, head_d;
  logic [OFFSET_BITS-1:0] base_q, base_d;
  logic [OFFSET_BITS-1:0] count_q, count_d;
  logic                   skip_q, skip_d;
  logic [OUT_W-1:0]       chunks_q, chunks_d;
  logic                   ovf_q, ovf_d;
  logic [IDX_W-1:0]       j_q, j_d;
  logic [IDX_W-1:0]       e_q, e_d;
  logic [IDX_W-1:0]       nxt_q, nxt_d;
  logic                   fmode_q, fmode_d;

  logic [IDX_W-1:0]  rel;
  logic [SUM_W-1:0]  sum;
  logic [ADDR_W-1:0] phys;
  logic              ram_we;
  logic [FLAG_W-1:0] wflags;
  logic [FLAG_W-1:0] rflags;
  logic              rd_sp;
  logic              rd_ct;
  logic [IDX_W-1:0]  lim_in;
  logic              clear;

  // Shared address unit: relative window index to physical RAM slot
  always_comb begin
    case (state_q)
      S_UPDATE: rel = fill_q;
      S_TR_RD:  rel = e_q - ONE;
      default:  rel = j_q;
    endcase
  end
  assign sum  = SUM_W'(head_q) + SUM_W'(rel);
  assign phys = (sum >= DEPTH_S) ? ADDR_W'(sum - DEPTH_S) : ADDR_W'(sum);

  // Flag window
  assign wflags = {ct_q, sp_q};

  wbtc_ram #(
    .WIDTH (FLAG_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (phys),
    .wdata_i (wflags),
    .raddr_i (phys),
    .rdata_o (rflags)
  );

  assign rd_sp = rflags[FLAG_SPACE_BIT];
  assign rd_ct = rflags[FLAG_CONT_BIT];

  // Limit clamped to 1..MAX_CHUNK
  always_comb begin
    if (chunk_limit_i == '0) begin
      lim_in = ONE;
    end else if (32'(chunk_limit_i) > MAX_CHUNK) begin
      lim_in = LIM_MAX;
    end else begin
      lim_in = IDX_W'(chunk_limit_i);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_UPDATE;
      S_UPDATE: state_d = S_DECIDE;
      S_DECIDE: begin
        if (fill_q > lim_q) begin
          state_d = S_SP_RD;
        end else if (fin_q) begin
          state_d = S_FIN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SP_RD:  state_d = S_SP_CHK;
      S_SP_CHK: begin
        if (rd_sp) begin
          state_d = S_TR_RD;
        end else if (j_q == ONE) begin
          state_d = S_CT_RD;
        end else begin
          state_d = S_SP_RD;
        end
      end
      S_CT_RD:  state_d = S_CT_CHK;
      S_CT_CHK: state_d = (rd_ct && (j_q != ONE)) ? S_CT_RD : S_TR_RD;
      S_TR_RD:  state_d = (e_q == '0) ? S_EMIT : S_TR_CHK;
      S_TR_CHK: state_d = rd_sp ? S_TR_RD : S_EMIT;
      S_EMIT: begin
        if (out_free_i) begin
          state_d = fmode_q ? S_IDLE : S_SK_RD;
        end
      end
      S_SK_RD:  state_d = (j_q >= fill_q) ? S_ADV : S_SK_CHK;
      S_SK_CHK: state_d = rd_sp ? S_SK_RD : S_ADV;
      S_ADV:    state_d = fin_q ? S_FIN : S_IDLE;
      S_FIN: begin
        if (fill_q != '0) begin
          state_d = S_TR_RD;
        end else if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    sp_d     = sp_q;
    ct_d     = ct_q;
    fin_d    = fin_q;
    lim_d    = lim_q;
    fill_d   = fill_q;
    head_d   = head_q;
    base_d   = base_q;
    count_d  = count_q;
    skip_d   = skip_q;
    chunks_d = chunks_q;
    ovf_d    = ovf_q;
    j_d      = j_q;
    e_d      = e_q;
    nxt_d    = nxt_q;
    fmode_d  = fmode_q;
    ram_we   = 1'b0;
    push_o   = 1'b0;
    clear    = 1'b0;
    in_ready_o = 1'b0;
    rec_o.chunk_start = OUT_W'(base_q);
    rec_o.chunk_end   = OUT_W'(sat_add(base_q, e_q));
    rec_o.chunk_index = chunks_q;
    rec_o.chunk_valid = 1'b1;
    rec_o.end_of_text = fmode_q;
    rec_o.overflow    = ovf_q;

    case (state_q)
      // Take a byte and classify it
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sp_d  = (text_byte_i == SPACE_CHAR);
          ct_d  = ((text_byte_i & CONT_MASK) == CONT_CODE);
          fin_d = final_byte_i;
          lim_d = lim_in;
        end
      end
      // Count the byte, then skip it or append its flags
      S_UPDATE: begin
        if (count_q == '1) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
        if (skip_q && sp_q) begin
          base_d = sat_add(base_q, ONE);
        end else begin
          skip_d = 1'b0;
          if (fill_q < DEPTH_I) begin
            ram_we = 1'b1;
            fill_d = fill_q + ONE;
          end
        end
      end
      S_DECIDE: begin
        j_d     = lim_q;
        fmode_d = 1'b0;
      end
      // Last space at or before the limit
      S_SP_CHK: begin
        if (rd_sp) begin
          e_d   = j_q;
          nxt_d = j_q;
        end else if (j_q == ONE) begin
          j_d = lim_q;
        end else begin
          j_d = j_q - ONE;
        end
      end
      // Hard break, backing off continuation bytes
      S_CT_CHK: begin
        if (rd_ct) begin
          if (j_q == ONE) begin
            e_d   = lim_q;
            nxt_d = lim_q;
          end else begin
            j_d = j_q - ONE;
          end
        end else begin
          e_d   = j_q;
          nxt_d = j_q;
        end
      end
      // Trim trailing spaces
      S_TR_CHK: begin
        if (rd_sp) begin
          e_d = e_q - ONE;
        end
      end
      S_EMIT: begin
        push_o = out_free_i;
        if (out_free_i) begin
          if (fmode_q) begin
            clear = 1'b1;
          end else begin
            chunks_d = chunks_q + 1'b1;
            j_d      = nxt_q;
          end
        end
      end
      // Skip spaces after the split
      S_SK_RD: begin
        if (j_q >= fill_q) begin
          j_d    = fill_q;
          skip_d = 1'b1;
        end
      end
      S_SK_CHK: begin
        if (rd_sp) begin
          j_d = j_q + ONE;
        end
      end
      // Drop the consumed part of the window
      S_ADV: begin
        head_d = phys;
        fill_d = fill_q - j_q;
        base_d = sat_add(base_q, j_q);
      end
      // End of text: last chunk or an empty closing record
      S_FIN: begin
        if (fill_q != '0) begin
          e_d     = fill_q;
          fmode_d = 1'b1;
        end else begin
          rec_o.chunk_start = OUT_W'(count_q);
          rec_o.chunk_end   = OUT_W'(count_q);
          rec_o.chunk_valid = 1'b0;
          rec_o.end_of_text = 1'b1;
          push_o = out_free_i;
          clear  = out_free_i;
        end
      end
      default: begin
      end
    endcase

    if (clear) begin
      fill_d   = '0;
      head_d   = '0;
      base_d   = '0;
      count_d  = '0;
      skip_d   = 1'b0;
      chunks_d = '0;
      ovf_d    = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fin_q    <= 1'b0;
      lim_q    <= LIM_MAX;
      fill_q   <= '0;
      head_q   <= '0;
      base_q   <= '0;
      count_q  <= '0;
      skip_q   <= 1'b0;
      chunks_q <= '0;
      ovf_q    <= 1'b0;
      j_q      <= '0;
      e_q      <= '0;
      nxt_q    <= '0;
      fmode_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      lim_q    <= lim_d;
      fill_q   <= fill_d;
      head_q   <= head_d;
      base_q   <= base_d;
      count_q  <= count_d;
      skip_q   <= skip_d;
      chunks_q <= chunks_d;
      ovf_q    <= ovf_d;
      j_q      <= j_d;
      e_q      <= e_d;
      nxt_q    <= nxt_d;
      fmode_q  <= fmode_d;
    end
  end

  // Byte class, no reset
  always_ff @(posedge clk_i) begin
    sp_q <= sp_d;
    ct_q <= ct_d;
  end

endmodule

// ===== dv/chunk_checker.sv =====
// ----------------------------------------------------------------------------
// chunk_checker
// Watches the text and chunk channels of the word boundary text chunker,
// predicts every chunk record from the accepted bytes and the chunk limit
// written on the configuration port, and compares the records in order.
// ----------------------------------------------------------------------------
module chunk_checker import wbtc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  wbtc_in_if               text_mon,
  wbtc_out_if              chunk_mon,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH   = WINDOW_DEPTH_DEF;
  localparam int unsigned LIM_MAX = MAX_CHUNK_DEF;
  localparam int unsigned OFF_MAX = (1 << OFFSET_BITS_DEF) - 1;

  // Shadow state of the chunker
  logic [FLAG_W-1:0] win_flags [DEPTH];
  int unsigned       win_fill;
  int unsigned       win_base;
  int unsigned       text_len;
  int unsigned       made_cnt;
  bit                skip_sp;
  bit                ovf_seen;
  logic [CFG_W-1:0]  limit_q;

  rec_t        expected_chunks [$];
  int unsigned fail_cnt = 0;
  int unsigned rec_seen = 0;

  assign fail_count_o = fail_cnt;

  function automatic int unsigned sat_off(input int unsigned a, input int unsigned b);
    longint unsigned s;
    s = a;
    s = s + b;
    if (s > OFF_MAX) s = OFF_MAX;
    return int'(s);
  endfunction

  function automatic bit flag_space(input int unsigned j);
    return (j < DEPTH) && win_flags[j][FLAG_SPACE_BIT];
  endfunction

  function automatic bit flag_cont(input int unsigned j);
    return (j < DEPTH) && win_flags[j][FLAG_CONT_BIT];
  endfunction

  task automatic clear_text();
    foreach (win_flags[k]) win_flags[k] = '0;
    win_fill = 0;
    win_base = 0;
    text_len = 0;
    made_cnt = 0;
    skip_sp  = 1'b0;
    ovf_seen = 1'b0;
  endtask

  task automatic push_chunk(input int unsigned start, input int unsigned stop,
                            input int unsigned idx, input logic valid, input logic eot);
    rec_t r;
    r.chunk_start = start[OUT_W-1:0];
    r.chunk_end   = stop[OUT_W-1:0];
    r.chunk_index = idx[OUT_W-1:0];
    r.chunk_valid = valid;
    r.end_of_text = eot;
    r.overflow    = ovf_seen;
    expected_chunks.push_back(r);
  endtask

  // One accepted byte: at most one split, then the closing record on the last byte
  task automatic predict_chunks(input logic [BYTE_W-1:0] b, input logic fin);
    int unsigned lim;
    int unsigned cut;
    int unsigned resume;
    int unsigned i;
    int unsigned j;
    lim = limit_q;
    if (lim < 1) lim = 1;
    if (lim > LIM_MAX) lim = LIM_MAX;

    if (text_len >= OFF_MAX) ovf_seen = 1'b1;
    else text_len++;

    // spaces straight after a split only move the base
    if (skip_sp && b == SPACE_CHAR) begin
      win_base = sat_off(win_base, 1);
    end else begin
      skip_sp = 1'b0;
      if (win_fill < DEPTH) begin
        win_flags[win_fill] = '0;
        win_flags[win_fill][FLAG_SPACE_BIT] = (b == SPACE_CHAR);
        win_flags[win_fill][FLAG_CONT_BIT]  = ((b & CONT_MASK) == CONT_CODE);
        win_fill++;
      end
    end

    if (win_fill >= lim + 1) begin
      // last space within the limit
      cut = 0;
      for (j = lim; j > 0; j--) begin
        if (flag_space(j)) begin
          cut = j;
          break;
        end
      end
      // hard break, stepping back to a character start unless that empties it
      if (cut == 0) begin
        cut = lim;
        while (cut > 0 && flag_cont(cut)) cut--;
        if (cut == 0) cut = lim;
      end
      resume = cut;
      while (cut > 0 && flag_space(cut - 1)) cut--;
      push_chunk(win_base, sat_off(win_base, cut), made_cnt, 1'b1, 1'b0);
      made_cnt = (made_cnt + 1) & OFF_MAX;
      while (resume < win_fill && flag_space(resume)) resume++;
      if (resume >= win_fill) begin
        resume  = win_fill;
        skip_sp = 1'b1;
      end
      for (i = 0; i + resume < win_fill && i < DEPTH; i++) begin
        win_flags[i] = win_flags[(i + resume) % DEPTH];
      end
      win_fill -= resume;
      win_base = sat_off(win_base, resume);
    end

    // closing record, carrying the remainder when there is one
    if (fin) begin
      if (win_fill > 0) begin
        cut = win_fill;
        while (cut > 0 && flag_space(cut - 1)) cut--;
        push_chunk(win_base, sat_off(win_base, cut), made_cnt, 1'b1, 1'b1);
      end else begin
        push_chunk(text_len, text_len, made_cnt, 1'b0, 1'b1);
      end
      clear_text();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("record %0d %s: got %0d, expected %0d",
                                rec_seen, name, got, want));
  endtask

  task automatic check_chunk();
    rec_t want;
    if (expected_chunks.size() == 0) begin
      report_mismatch($sformatf("record %0d not expected (start %0d end %0d index %0d)",
                                rec_seen, chunk_mon.chunk_start, chunk_mon.chunk_end,
                                chunk_mon.chunk_index));
    end else begin
      want = expected_chunks.pop_front();
      check_field("chunk_start", chunk_mon.chunk_start, want.chunk_start);
      check_field("chunk_end",   chunk_mon.chunk_end,   want.chunk_end);
      check_field("chunk_index", chunk_mon.chunk_index, want.chunk_index);
      check_field("chunk_valid", OUT_W'(chunk_mon.chunk_valid), OUT_W'(want.chunk_valid));
      check_field("end_of_text", OUT_W'(chunk_mon.end_of_text), OUT_W'(want.end_of_text));
      check_field("overflow",    OUT_W'(chunk_mon.overflow),    OUT_W'(want.overflow));
    end
    rec_seen++;
  endtask

  // Sample both channels and the config port on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      limit_q = LIMIT_RST;
      expected_chunks.delete();
      pending_o <= 0;
    end else begin
      // a byte taken on the write edge still sees the old limit
      if (text_mon.valid && text_mon.ready)
        predict_chunks(text_mon.text_byte, text_mon.final_byte);
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (chunk_mon.valid && chunk_mon.ready) check_chunk();
      pending_o <= expected_chunks.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the word boundary text chunker: directed texts
// for the corner cases, one text sent back to back, then random word and
// noise texts under changing chunk limits, with random pacing on both
// channels. Checking is done by chunk_checker.
// ----------------------------------------------------------------------------
module tb_top import wbtc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS  = 440;
  localparam int unsigned SETTLE_CYCLES = 4 * MAX_CHUNK_DEF + 40;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               hurry = 1'b0;
  int unsigned      cycles = 0;
  int unsigned      random_sent = 0;
  int unsigned      fails;
  int unsigned      pending;

  wbtc_in_if  text_if ();
  wbtc_out_if chunk_if ();

  word_boundary_text_chunker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .text_i     (text_if),
    .chunk_o    (chunk_if)
  );

  chunk_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .text_mon    (text_if),
    .chunk_mon   (chunk_if),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always #4 clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if (hurry || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 7'd1;
      1: return 7'd2;
      2: return 7'd67;
      3: return 7'd0;
      4: return 7'd127;
      5, 6, 7: return CFG_W'($urandom_range(3, 20));
      8: return CFG_W'($urandom_range(21, 66));
      default: return CFG_W'($urandom_range(0, 127));
    endcase
  endfunction

  // Result side: random stall before each transfer
  initial begin : out_pacing
    int unsigned gap;
    chunk_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        chunk_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      chunk_if.ready <= 1'b1;
      do @(posedge clk); while (!chunk_if.valid);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= b;
    text_if.final_byte <= fin;
    do @(posedge clk); while (!text_if.ready);
  endtask

  // Hold the sender until every expected record is in, then let the block settle
  task automatic drain();
    text_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sends a text, now and then changing the limit part-way through
  task automatic send_text(ref logic [BYTE_W-1:0] q[$]);
    logic fin;
    foreach (q[i]) begin
      fin = (i == q.size() - 1);
      if (!fin && i > 0 && $urandom_range(0, 49) == 0) set_limit(pick_limit());
      send_byte(q[i], fin);
    end
  endtask

  // Words, UTF-8 characters and long unbroken runs, separated by spaces
  task automatic build_words(ref logic [BYTE_W-1:0] q[$], input int unsigned len);
    int unsigned n;
    q.delete();
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) q.push_back(SPACE_CHAR);
    while (q.size() < len) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 3);
          case (n)
            1: q.push_back(BYTE_W'($urandom_range(8'hC2, 8'hDF)));
            2: q.push_back(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
            default: q.push_back(BYTE_W'($urandom_range(8'hF0, 8'hF4)));
          endcase
          repeat (n) q.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
        end
        1: begin
          repeat ($urandom_range(10, 90)) q.push_back(BYTE_W'($urandom_range(8'h61, 8'h7A)));
        end
        2: begin
          repeat ($urandom_range(1, 6)) q.push_back(BYTE_W'($urandom_range(8'h21, 8'h7E)));
        end
        default: begin
          repeat ($urandom_range(1, 10)) q.push_back(BYTE_W'($urandom_range(8'h61, 8'h7A)));
        end
      endcase
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(0, 5)) q.push_back(SPACE_CHAR);
      else q.push_back(SPACE_CHAR);
    end
  endtask

  task automatic build_noise(ref logic [BYTE_W-1:0] q[$], input int unsigned len);
    q.delete();
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) q.push_back(SPACE_CHAR);
      else q.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] txt [$];
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    text_if.valid      <= 1'b0;
    text_if.text_byte  <= '0;
    text_if.final_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a lone space: chunk left empty by trimming
    send_byte(SPACE_CHAR, 1'b1);

    // limit of one, extreme byte values, spaces skipped after a split
    set_limit(7'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(SPACE_CHAR, 1'b0);
    send_byte(SPACE_CHAR, 1'b0);
    send_byte(8'h00, 1'b1);

    // only skipped spaces left at the end: closing record without a chunk
    send_byte(8'h61, 1'b0);
    send_byte(SPACE_CHAR, 1'b0);
    send_byte(SPACE_CHAR, 1'b1);

    // hard break backing off continuation bytes, then one that cannot back off
    set_limit(7'd3);
    send_byte(8'h78, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);

    // limit lowered part-way through a text, remainder closed as one chunk
    set_limit(7'd127);
    repeat (10) send_byte(8'h7A, 1'b0);
    set_limit(7'd0);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h7A, 1'b1);

    // one text sent back to back
    set_limit(7'd10);
    hurry = 1'b1;
    build_words(txt, 60);
    send_text(txt);
    hurry = 1'b0;

    // random texts under changing limits
    while (random_sent < RANDOM_ITEMS) begin
      hurry = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          set_limit(pick_limit());
        end
        1, 2: begin
          build_noise(txt, $urandom_range(1, 30));
          send_text(txt);
          random_sent += txt.size();
        end
        default: begin
          build_words(txt, $urandom_range(3, 70));
          send_text(txt);
          random_sent += txt.size();
        end
      endcase
    end
    hurry = 1'b0;

    drain();
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
